// ----- rtl/qdec_pkg.sv -----
// ----------------------------------------------------------------------------
// qdec_pkg
// Shared types and constants of the quadrature decoder with speed output.
// ----------------------------------------------------------------------------
package qdec_pkg;

    // Default widths of the edge counter and of the tick timer
    localparam int DEF_COUNT_WIDTH = 32;
    localparam int DEF_TIME_WIDTH  = 32;

    // Width of the angle and speed results, and their saturation limits
    localparam int RES_W = 48;
    localparam logic [RES_W-1:0] S48_MAX = {1'b0, {(RES_W-1){1'b1}}};
    localparam logic [RES_W-1:0] S48_NEG = {1'b1, {(RES_W-1){1'b0}}};

    // Configuration port
    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 64;

    typedef enum logic [1:0] {
        REG_EDGE_TABLE = 2'd0,
        REG_DEG_PER_EDGE = 2'd1,
        REG_SPEED_SCALE = 2'd2,
        REG_TIMEOUT = 2'd3
    } qdec_reg_idx_t;

    // Request kinds
    localparam logic REQ_TICK = 1'b0;
    localparam logic REQ_LOAD = 1'b1;

    // Direction table codes; every other code means no movement
    localparam logic [1:0] CODE_FWD = 2'b01;
    localparam logic [1:0] CODE_REV = 2'b11;

    // Direction values
    localparam logic signed [1:0] DIR_FWD  = 2'sb01;
    localparam logic signed [1:0] DIR_REV  = 2'sb11;
    localparam logic signed [1:0] DIR_NONE = 2'sb00;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SETUP,
        ST_CALC,
        ST_FINISH
    } qdec_state_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic capture;   // take in the accepted item and update edge state
        logic setup;     // load multiplier and divider operands
        logic step;      // advance multiplier and divider by one bit
        logic publish;   // load the result register
    } qdec_cmd_t;

endpackage

// ----- rtl/qdec_ctrl.sv -----
// ----------------------------------------------------------------------------
// qdec_ctrl
// Sequencer of the decoder: accepts an item, runs the bit-serial angle and
// speed steps, and hands the result to the output register.
// ----------------------------------------------------------------------------
module qdec_ctrl #(
    parameter int STEPS = 48
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_stall,
    output logic                res_valid,
    input  logic                res_stall,
    output qdec_pkg::qdec_cmd_t cmd
);
    import qdec_pkg::*;

    localparam int CNT_W = $clog2(STEPS);

    qdec_state_t      state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             res_valid_reg, res_valid_next;
    logic             last_step;

    assign last_step = (cnt_reg == CNT_W'(STEPS - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        cmd         = '0;
        req_stall   = 1'b1;
        res_valid_next = res_valid_reg && res_stall;
        unique case (state_reg)
            ST_IDLE:
            begin
                req_stall = 1'b0;
                if (req_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_SETUP;
                end
            end
            ST_SETUP:
            begin
                cmd.setup  = 1'b1;
                cnt_next   = '0;
                state_next = ST_CALC;
            end
            ST_CALC:
            begin
                cmd.step = 1'b1;
                cnt_next = cnt_reg + 1'b1;
                if (last_step)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                // hold until the output register is free
                if (!res_valid_reg || !res_stall)
                begin
                    cmd.publish    = 1'b1;
                    res_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign res_valid = res_valid_reg;

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall) |=> (state_reg == ST_SETUP))
        else $error("accepted item did not start the sequence");

    a_rise_after_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid_reg) |-> ($past(state_reg) == ST_FINISH))
        else $error("result shown without a finished sequence");

    a_calc_length: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CALC && last_step) |=> (state_reg == ST_FINISH))
        else $error("calculation did not end after the last step");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && res_stall) |-> !cmd.publish)
        else $error("stalled result overwritten");

endmodule

// ----- rtl/qdec_dp.sv -----
// ----------------------------------------------------------------------------
// qdec_dp
// Datapath: edge detection, direction lookup, counter and timer, a bit-serial
// saturating multiplier for the angle and a restoring divider for the speed.
// ----------------------------------------------------------------------------
module qdec_dp #(
    parameter int COUNT_WIDTH = qdec_pkg::DEF_COUNT_WIDTH,
    parameter int TIME_WIDTH  = qdec_pkg::DEF_TIME_WIDTH,
    parameter int STEPS       = 48
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  qdec_pkg::qdec_cmd_t            cmd,
    input  logic [31:0]                    edge_table,
    input  logic [31:0]                    angle_step,
    input  logic [qdec_pkg::RES_W-1:0]     speed_scale,
    input  logic [31:0]                    timeout_ticks,
    input  logic                           req_type,
    input  logic                           pin_a,
    input  logic                           pin_b,
    input  logic signed [31:0]             load_value,
    output logic signed [31:0]             position_count,
    output logic signed [qdec_pkg::RES_W-1:0] angle_out,
    output logic signed [1:0]              direction_out,
    output logic signed [qdec_pkg::RES_W-1:0] speed_out,
    output logic                           edge_seen
);
    import qdec_pkg::*;

    localparam int CW    = COUNT_WIDTH;
    localparam int TW    = TIME_WIDTH;
    localparam int CMP_W = (TW > 32) ? TW : 32;

    // edge state
    logic                last_a_reg, last_a_next;
    logic [3:0]          hist_reg, hist_next;
    logic signed [1:0]   dir_reg, dir_next;
    logic [CW-1:0]       count_reg, count_next;
    logic [TW-1:0]       tick_reg, tick_next;
    logic [TW-1:0]       last_edge_reg, last_edge_next;
    logic [TW-1:0]       interval_reg, interval_next;
    logic                edge_reg, edge_next;

    // arithmetic
    logic [STEPS-1:0]    mag_reg;
    logic                neg_reg;
    logic [RES_W-1:0]    acc_reg;
    logic                sticky_reg;
    logic [STEPS-1:0]    dvd_reg;
    logic [TW-1:0]       rem_reg;
    logic [STEPS-1:0]    quo_reg;
    logic                spd_en_reg;

    logic [63:0]         load_ext;
    logic [3:0]          hist_new;
    logic [31:0]         table_sh;
    logic [1:0]          code;
    logic [TW-1:0]       tick_inc;
    logic [CW-1:0]       count_mag;
    logic [TW-1:0]       since;
    logic [RES_W+1:0]    acc_sum;
    logic [TW:0]         rem_sh;
    logic                rem_ge;
    logic [RES_W-1:0]    ang_mag, spd_mag, quo48;
    logic [RES_W-1:0]    angle_val, speed_val;
    logic [63:0]         count_ext;

    // ---------------- edge and count update ----------------
    assign load_ext = {{32{load_value[31]}}, load_value};
    assign tick_inc = tick_reg + 1'b1;
    assign hist_new = {hist_reg[1:0], pin_a, pin_b};
    assign table_sh = edge_table >> {hist_new, 1'b0};
    assign code     = table_sh[1:0];

    always_comb
    begin
        last_a_next    = last_a_reg;
        hist_next      = hist_reg;
        dir_next       = dir_reg;
        count_next     = count_reg;
        tick_next      = tick_reg;
        last_edge_next = last_edge_reg;
        interval_next  = interval_reg;
        edge_next      = edge_reg;
        if (cmd.capture)
        begin
            edge_next = 1'b0;
            if (req_type == REQ_TICK)
            begin
                tick_next   = tick_inc;
                last_a_next = pin_a;
                if (pin_a != last_a_reg)
                begin
                    edge_next      = 1'b1;
                    interval_next  = tick_inc - last_edge_reg;
                    last_edge_next = tick_inc;
                    hist_next      = hist_new;
                    if (code == CODE_FWD)
                    begin
                        dir_next   = DIR_FWD;
                        count_next = count_reg + 1'b1;
                    end
                    else if (code == CODE_REV)
                    begin
                        dir_next   = DIR_REV;
                        count_next = count_reg - 1'b1;
                    end
                    else
                    begin
                        dir_next = DIR_NONE;
                    end
                end
            end
            else
            begin
                count_next = load_ext[CW-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_a_reg    <= 1'b0;
            hist_reg      <= '0;
            dir_reg       <= DIR_NONE;
            count_reg     <= '0;
            tick_reg      <= '0;
            last_edge_reg <= '0;
            interval_reg  <= '0;
            edge_reg      <= 1'b0;
        end
        else
        begin
            last_a_reg    <= last_a_next;
            hist_reg      <= hist_next;
            dir_reg       <= dir_next;
            count_reg     <= count_next;
            tick_reg      <= tick_next;
            last_edge_reg <= last_edge_next;
            interval_reg  <= interval_next;
            edge_reg      <= edge_next;
        end
    end

    // ---------------- bit-serial multiply and divide ----------------
    assign count_mag = count_reg[CW-1] ? (~count_reg + 1'b1) : count_reg;
    assign since     = tick_reg - last_edge_reg;

    // MSB-first shift-add; flag any excursion past 48 bits
    assign acc_sum = {1'b0, acc_reg, 1'b0}
                   + ((RES_W + 2)'(angle_step) & {(RES_W + 2){mag_reg[STEPS-1]}});

    // restoring division step
    assign rem_sh = {rem_reg, dvd_reg[STEPS-1]};
    assign rem_ge = (rem_sh >= {1'b0, interval_reg});

    always_ff @(posedge clk)
    begin
        if (cmd.setup)
        begin
            mag_reg    <= STEPS'(count_mag);
            neg_reg    <= count_reg[CW-1];
            acc_reg    <= '0;
            sticky_reg <= 1'b0;
            dvd_reg    <= STEPS'(speed_scale);
            rem_reg    <= '0;
            quo_reg    <= '0;
            spd_en_reg <= (CMP_W'(since) < CMP_W'(timeout_ticks))
                          && (interval_reg != '0) && (dir_reg != DIR_NONE);
        end
        else if (cmd.step)
        begin
            mag_reg    <= {mag_reg[STEPS-2:0], 1'b0};
            acc_reg    <= acc_sum[RES_W-1:0];
            sticky_reg <= sticky_reg || (acc_sum[RES_W+1:RES_W] != 2'b00);
            dvd_reg    <= {dvd_reg[STEPS-2:0], 1'b0};
            rem_reg    <= rem_ge ? TW'(rem_sh - {1'b0, interval_reg}) : rem_sh[TW-1:0];
            quo_reg    <= {quo_reg[STEPS-2:0], rem_ge};
        end
    end

    // ---------------- saturation and result register ----------------
    assign quo48 = quo_reg[RES_W-1:0];

    always_comb
    begin
        if (neg_reg)
        begin
            ang_mag   = (sticky_reg || acc_reg > S48_NEG) ? S48_NEG : acc_reg;
            angle_val = ~ang_mag + 1'b1;
        end
        else
        begin
            ang_mag   = (sticky_reg || acc_reg > S48_MAX) ? S48_MAX : acc_reg;
            angle_val = ang_mag;
        end
        if (dir_reg == DIR_REV)
        begin
            spd_mag   = (quo48 > S48_NEG) ? S48_NEG : quo48;
            speed_val = ~spd_mag + 1'b1;
        end
        else
        begin
            spd_mag   = (quo48 > S48_MAX) ? S48_MAX : quo48;
            speed_val = spd_mag;
        end
        if (!spd_en_reg)
        begin
            speed_val = '0;
        end
    end

    assign count_ext = 64'(count_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.publish)
        begin
            position_count <= count_ext[31:0];
            angle_out      <= angle_val;
            direction_out  <= dir_reg;
            speed_out      <= speed_val;
            edge_seen      <= edge_reg;
        end
    end

endmodule

// ----- rtl/quadrature_decoder_with_speed.sv -----
// ----------------------------------------------------------------------------
// quadrature_decoder_with_speed
// Quadrature decoder with edge counter, angle and speed, APB configuration.
// ----------------------------------------------------------------------------
// Each request item is either a tick (advance the tick timer by one and
// sample channels A and B) or a load (set the edge count from load_value).
// A change of A is an edge: the ticks since the previous edge are kept as
// the edge interval, the A,B pair is shifted into a 4-bit history, and the
// history selects a 2-bit direction from edge_table (01 forward, 11 reverse,
// anything else no movement). Every item returns one result item with the
// count, the angle (count times the angle step per edge, saturated Q32.16),
// the direction, the speed (direction times speed_scale over the interval,
// saturated, zero once timeout_ticks have passed without an edge or while no
// interval is known) and an edge flag. After acceptance the block runs a setup
// step, the shared bit-serial loop over STEPS bits, STEPS being the larger of
// COUNT_WIDTH and 48, and a finish step that waits until the output register
// is free and loads it. The next item is taken only after the finish step.
// The loop forms the angle product and the speed quotient one bit per cycle.
// The result waits in an output register, so the next item is accepted while
// a finished result is still stalled. Registers are at byte addresses 0, 8,
// 16 and 24 on a 64-bit data bus; write them only while the block is idle.
// ----------------------------------------------------------------------------
module quadrature_decoder_with_speed #(
    parameter int COUNT_WIDTH = qdec_pkg::DEF_COUNT_WIDTH,
    parameter int TIME_WIDTH  = qdec_pkg::DEF_TIME_WIDTH
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // configuration port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [qdec_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [qdec_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [qdec_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready,
    // request channel
    input  logic                                req_valid,
    output logic                                req_stall,
    input  logic                                req_type,
    input  logic                                pin_a,
    input  logic                                pin_b,
    input  logic signed [31:0]                  load_value,
    // result channel
    output logic                                res_valid,
    input  logic                                res_stall,
    output logic signed [31:0]                  position_count,
    output logic signed [qdec_pkg::RES_W-1:0]   angle_out,
    output logic signed [1:0]                   direction_out,
    output logic signed [qdec_pkg::RES_W-1:0]   speed_out,
    output logic                                edge_seen
);
    import qdec_pkg::*;

    // shared loop length: one bit of the count magnitude and of the
    // 48-bit dividend per cycle
    localparam int STEPS = (COUNT_WIDTH > RES_W) ? COUNT_WIDTH : RES_W;

    logic [31:0]      edge_table_reg;
    logic [31:0]      deg_per_edge_reg;
    logic [RES_W-1:0] speed_scale_reg;
    logic [31:0]      timeout_reg;
    logic             cfg_wr;
    qdec_reg_idx_t    reg_idx;
    qdec_cmd_t        cmd;

    // ---------------- configuration registers ----------------
    // Only the register index bits are decoded; the byte offset is ignored.
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign reg_idx = qdec_reg_idx_t'(paddr[4:3]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            edge_table_reg   <= '0;
            deg_per_edge_reg <= '0;
            speed_scale_reg  <= '0;
            timeout_reg      <= '0;
        end
        else if (cfg_wr)
        begin
            unique case (reg_idx)
                REG_EDGE_TABLE:   edge_table_reg   <= pwdata[31:0];
                REG_DEG_PER_EDGE: deg_per_edge_reg <= pwdata[31:0];
                REG_SPEED_SCALE:  speed_scale_reg  <= pwdata[RES_W-1:0];
                REG_TIMEOUT:      timeout_reg      <= pwdata[31:0];
                default:          edge_table_reg   <= edge_table_reg;
            endcase
        end
    end

    // read back the addressed register
    always_comb
    begin
        unique case (reg_idx)
            REG_EDGE_TABLE:   prdata = APB_DATA_W'(edge_table_reg);
            REG_DEG_PER_EDGE: prdata = APB_DATA_W'(deg_per_edge_reg);
            REG_SPEED_SCALE:  prdata = APB_DATA_W'(speed_scale_reg);
            REG_TIMEOUT:      prdata = APB_DATA_W'(timeout_reg);
            default:          prdata = '0;
        endcase
    end

    // ---------------- sequencer ----------------
    // Drive the accept, the setup cycle, the shared bit loop and the
    // hand-over into the output register.
    qdec_ctrl #(
        .STEPS (STEPS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .cmd       (cmd)
    );

    // ---------------- datapath ----------------
    // Hold the edge state, count and timer, and work out angle and speed.
    qdec_dp #(
        .COUNT_WIDTH (COUNT_WIDTH),
        .TIME_WIDTH  (TIME_WIDTH),
        .STEPS       (STEPS)
    ) u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .edge_table       (edge_table_reg),
        .angle_step       (deg_per_edge_reg),
        .speed_scale      (speed_scale_reg),
        .timeout_ticks    (timeout_reg),
        .req_type         (req_type),
        .pin_a            (pin_a),
        .pin_b            (pin_b),
        .load_value       (load_value),
        .position_count   (position_count),
        .angle_out        (angle_out),
        .direction_out    (direction_out),
        .speed_out        (speed_out),
        .edge_seen        (edge_seen)
    );

endmodule
